@@ src/rbcp_pkg.sv @@
// shared types and constants for the region blit chunk packetizer
package rbcp_pkg;

    localparam int ADDR_WIDTH      = 32;
    localparam int COUNT_WIDTH     = 24;
    localparam int ROW_WIDTH       = 13;
    localparam int SIZE_WIDTH      = 11;
    localparam int SLOT_WIDTH      = 10;
    localparam int LANE_WIDTH      = 11;
    localparam int CFG_INDEX_WIDTH = 2;
    localparam int CFG_DATA_WIDTH  = 32;

    localparam logic [CFG_INDEX_WIDTH-1:0] CFG_SCREEN_BASE = 2'd0;
    localparam logic [CFG_INDEX_WIDTH-1:0] CFG_LINE_STRIDE = 2'd1;
    localparam logic [CFG_INDEX_WIDTH-1:0] CFG_PACKET_SIZE = 2'd2;

    localparam logic [ROW_WIDTH-1:0]  STRIDE_RESET = 13'd800;
    localparam logic [SIZE_WIDTH-1:0] SIZE_RESET   = 11'd512;
    localparam logic [SIZE_WIDTH-1:0] SIZE_MIN     = 11'd2;
    localparam logic [SIZE_WIDTH-1:0] SIZE_MAX     = 11'd1024;

    localparam logic ACT_START   = 1'b0;
    localparam logic ACT_ADVANCE = 1'b1;

    typedef enum logic [1:0] {
        KIND_BEGIN = 2'd0,
        KIND_READ  = 2'd1,
        KIND_PAD   = 2'd2,
        KIND_IDLE  = 2'd3
    } kind_t;

    typedef struct packed {
        logic                   action;
        logic [COUNT_WIDTH-1:0] region_total;
        logic [COUNT_WIDTH-1:0] region_offset;
        logic [ROW_WIDTH-1:0]   row_bytes;
    } req_t;

    typedef struct packed {
        kind_t                 slot_kind;
        logic [ADDR_WIDTH-1:0] read_address;
        logic [LANE_WIDTH-1:0] byte_lane;
        logic                  packet_done;
        logic                  region_done;
    } result_t;

endpackage

@@ src/rbcp_in_stage.sv @@
// input request register with flow control toward the result register
module rbcp_in_stage (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  rbcp_pkg::req_t     req_in,
    input  logic               down_free,
    output logic               step,
    output rbcp_pkg::req_t     req_out
);

    logic           valid_reg;
    rbcp_pkg::req_t req_reg;
    logic           in_fire;

    assign step     = valid_reg && down_free;
    assign in_stall = valid_reg && !down_free;
    assign in_fire  = in_valid && !in_stall;
    assign req_out  = req_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_fire)
        begin
            valid_reg <= 1'b1;
        end
        else if (step)
        begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            req_reg <= req_in;
        end
    end

endmodule

@@ src/rbcp_core.sv @@
// configuration registers, region walk state and slot computation
module rbcp_core (
    input  logic                                    clk,
    input  logic                                    rst_n,
    input  logic                                    cfg_write,
    input  logic [rbcp_pkg::CFG_INDEX_WIDTH-1:0]    cfg_index,
    input  logic [rbcp_pkg::CFG_DATA_WIDTH-1:0]     cfg_data,
    input  logic                                    step,
    input  rbcp_pkg::req_t                          req,
    output rbcp_pkg::result_t                       result
);

    logic [rbcp_pkg::ADDR_WIDTH-1:0]  screen_base_reg;
    logic [rbcp_pkg::ROW_WIDTH-1:0]   line_stride_reg;
    logic [rbcp_pkg::SIZE_WIDTH-1:0]  packet_size_reg;

    logic [rbcp_pkg::ADDR_WIDTH-1:0]  cursor_reg, cursor_next;
    logic [rbcp_pkg::COUNT_WIDTH-1:0] bytes_left_reg, bytes_left_next;
    logic [rbcp_pkg::ROW_WIDTH-1:0]   row_left_reg, row_left_next;
    logic [rbcp_pkg::ROW_WIDTH-1:0]   row_length_reg, row_length_next;
    logic [rbcp_pkg::SLOT_WIDTH-1:0]  slot_index_reg, slot_index_next;
    logic                             active_reg, active_next;

    logic [rbcp_pkg::ROW_WIDTH-1:0]   row_start;
    logic [rbcp_pkg::ROW_WIDTH:0]     skip;
    logic [rbcp_pkg::ADDR_WIDTH-1:0]  cursor_eff;
    logic [rbcp_pkg::ROW_WIDTH-1:0]   row_eff;
    logic                             do_read;
    logic [rbcp_pkg::COUNT_WIDTH-1:0] bytes_after;
    logic [rbcp_pkg::SIZE_WIDTH-1:0]  size_clamped;
    logic [rbcp_pkg::SIZE_WIDTH-1:0]  slots;
    logic [rbcp_pkg::LANE_WIDTH-1:0]  slot_inc;
    logic                             close_pkt;

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            screen_base_reg <= '0;
            line_stride_reg <= rbcp_pkg::STRIDE_RESET;
            packet_size_reg <= rbcp_pkg::SIZE_RESET;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                rbcp_pkg::CFG_SCREEN_BASE:
                    screen_base_reg <= cfg_data[rbcp_pkg::ADDR_WIDTH-1:0];
                rbcp_pkg::CFG_LINE_STRIDE:
                    line_stride_reg <= cfg_data[rbcp_pkg::ROW_WIDTH-1:0];
                rbcp_pkg::CFG_PACKET_SIZE:
                    packet_size_reg <= cfg_data[rbcp_pkg::SIZE_WIDTH-1:0];
                default:
                begin
                end
            endcase
        end
    end

    // row reload and skip
    assign row_start = (req.row_bytes == '0) ? rbcp_pkg::ROW_WIDTH'(1) : req.row_bytes;
    assign skip      = {1'b0, line_stride_reg} - {1'b0, row_length_reg};
    assign row_eff   = (row_left_reg == '0) ? row_length_reg : row_left_reg;
    assign cursor_eff = (row_left_reg == '0)
        ? cursor_reg + {{(rbcp_pkg::ADDR_WIDTH-rbcp_pkg::ROW_WIDTH-1){skip[rbcp_pkg::ROW_WIDTH]}},
                        skip}
        : cursor_reg;
    assign do_read     = (bytes_left_reg != '0) && (row_eff != '0);
    assign bytes_after = do_read ? bytes_left_reg - 1'b1 : bytes_left_reg;

    // packet slot bookkeeping
    always_comb
    begin
        if (packet_size_reg < rbcp_pkg::SIZE_MIN)
        begin
            size_clamped = rbcp_pkg::SIZE_MIN;
        end
        else if (packet_size_reg > rbcp_pkg::SIZE_MAX)
        begin
            size_clamped = rbcp_pkg::SIZE_MAX;
        end
        else
        begin
            size_clamped = packet_size_reg;
        end
    end

    assign slots     = size_clamped - 1'b1;
    assign slot_inc  = {1'b0, slot_index_reg} + 1'b1;
    assign close_pkt = (slot_inc >= slots);

    always_comb
    begin
        cursor_next     = cursor_reg;
        bytes_left_next = bytes_left_reg;
        row_left_next   = row_left_reg;
        row_length_next = row_length_reg;
        slot_index_next = slot_index_reg;
        active_next     = active_reg;
        result          = '{slot_kind: rbcp_pkg::KIND_IDLE, read_address: '0,
                            byte_lane: '0, packet_done: 1'b0, region_done: 1'b0};
        if (req.action == rbcp_pkg::ACT_START)
        begin
            cursor_next      = screen_base_reg
                             + {{(rbcp_pkg::ADDR_WIDTH-rbcp_pkg::COUNT_WIDTH){1'b0}},
                                req.region_offset};
            bytes_left_next  = req.region_total;
            row_length_next  = row_start;
            row_left_next    = row_start;
            slot_index_next  = '0;
            active_next      = 1'b1;
            result.slot_kind = rbcp_pkg::KIND_BEGIN;
        end
        else if (active_reg)
        begin
            bytes_left_next  = bytes_after;
            row_left_next    = (row_eff != '0) ? row_eff - 1'b1 : row_eff;
            result.byte_lane = slot_inc ^ rbcp_pkg::LANE_WIDTH'(1);
            if (do_read)
            begin
                result.slot_kind    = rbcp_pkg::KIND_READ;
                result.read_address = cursor_eff;
                cursor_next         = cursor_eff + 1'b1;
            end
            else
            begin
                result.slot_kind = rbcp_pkg::KIND_PAD;
                cursor_next      = cursor_eff;
            end
            if (close_pkt)
            begin
                result.packet_done = 1'b1;
                slot_index_next    = '0;
                if (bytes_after == '0)
                begin
                    result.region_done = 1'b1;
                    active_next        = 1'b0;
                end
            end
            else
            begin
                slot_index_next = slot_inc[rbcp_pkg::SLOT_WIDTH-1:0];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cursor_reg     <= '0;
            bytes_left_reg <= '0;
            row_left_reg   <= '0;
            row_length_reg <= '0;
            slot_index_reg <= '0;
            active_reg     <= 1'b0;
        end
        else if (step)
        begin
            cursor_reg     <= cursor_next;
            bytes_left_reg <= bytes_left_next;
            row_left_reg   <= row_left_next;
            row_length_reg <= row_length_next;
            slot_index_reg <= slot_index_next;
            active_reg     <= active_next;
        end
    end

endmodule

@@ src/rbcp_out_stage.sv @@
// result register toward the output channel
module rbcp_out_stage (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                step,
    input  rbcp_pkg::result_t   result_in,
    output logic                free,
    output logic                out_valid,
    input  logic                out_stall,
    output rbcp_pkg::result_t   result_out
);

    logic              valid_reg;
    rbcp_pkg::result_t result_reg;

    assign free       = !valid_reg || !out_stall;
    assign out_valid  = valid_reg;
    assign result_out = result_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (step)
        begin
            valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (step)
        begin
            result_reg <= result_in;
        end
    end

endmodule

@@ src/region_blit_chunk_packetizer.sv @@
// top level of the region blit chunk packetizer
// a request is held in the input register until the result register is free, then its result is registered there
// throughput: one request per cycle while the output is not stalled; slot state updates once per request
// a stalled output holds the result register and backs up into the input register
// reset clears all walk state and loads screen_base 0, line_stride 800, packet_size 512
// no result is pending after reset and the region walker is idle
module region_blit_chunk_packetizer (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  cfg_write,
    input  logic [rbcp_pkg::CFG_INDEX_WIDTH-1:0]  cfg_index,
    input  logic [rbcp_pkg::CFG_DATA_WIDTH-1:0]   cfg_data,
    input  logic                                  in_valid,
    output logic                                  in_stall,
    input  logic                                  action,
    input  logic [rbcp_pkg::COUNT_WIDTH-1:0]      region_total,
    input  logic [rbcp_pkg::COUNT_WIDTH-1:0]      region_offset,
    input  logic [rbcp_pkg::ROW_WIDTH-1:0]        row_bytes,
    output logic                                  out_valid,
    input  logic                                  out_stall,
    output logic [1:0]                            slot_kind,
    output logic [rbcp_pkg::ADDR_WIDTH-1:0]       read_address,
    output logic [rbcp_pkg::LANE_WIDTH-1:0]       byte_lane,
    output logic                                  packet_done,
    output logic                                  region_done
);

    rbcp_pkg::req_t    req_in;
    rbcp_pkg::req_t    req_q;
    rbcp_pkg::result_t result_d;
    rbcp_pkg::result_t result_q;
    logic              step;
    logic              down_free;

    assign req_in = '{action: action, region_total: region_total,
                      region_offset: region_offset, row_bytes: row_bytes};

    rbcp_in_stage u_in (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .req_in    (req_in),
        .down_free (down_free),
        .step      (step),
        .req_out   (req_q)
    );

    rbcp_core u_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .step      (step),
        .req       (req_q),
        .result    (result_d)
    );

    rbcp_out_stage u_out (
        .clk        (clk),
        .rst_n      (rst_n),
        .step       (step),
        .result_in  (result_d),
        .free       (down_free),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .result_out (result_q)
    );

    assign slot_kind    = result_q.slot_kind;
    assign read_address = result_q.read_address;
    assign byte_lane    = result_q.byte_lane;
    assign packet_done  = result_q.packet_done;
    assign region_done  = result_q.region_done;

endmodule

@@ src/rbcp_checker.sv @@
// port level checks for the region blit chunk packetizer
module rbcp_checker (
    input logic                                  clk,
    input logic                                  rst_n,
    input logic                                  out_valid,
    input logic                                  out_stall,
    input logic [1:0]                            slot_kind,
    input logic [rbcp_pkg::ADDR_WIDTH-1:0]       read_address,
    input logic [rbcp_pkg::LANE_WIDTH-1:0]       byte_lane,
    input logic                                  packet_done,
    input logic                                  region_done
);

    // a stalled result keeps its kind, address and lane
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(slot_kind)
            && $stable(read_address) && $stable(byte_lane))
        else $error("stalled result changed");

    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && region_done |-> packet_done)
        else $error("region end without packet end");

    // only reads carry an address
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && slot_kind != rbcp_pkg::KIND_READ |-> read_address == '0)
        else $error("address on a non-read result");

    // begin and idle results carry no lane and close nothing
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (slot_kind == rbcp_pkg::KIND_BEGIN || slot_kind == rbcp_pkg::KIND_IDLE)
            |-> byte_lane == '0 && !packet_done && !region_done)
        else $error("begin or idle result with slot fields");

endmodule

bind region_blit_chunk_packetizer rbcp_checker u_rbcp_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .slot_kind    (slot_kind),
    .read_address (read_address),
    .byte_lane    (byte_lane),
    .packet_done  (packet_done),
    .region_done  (region_done)
);
